// ----- hw/rtl/fgp_pkg.sv -----
// Package of the frame GCRA policer: register map, reset values, shared types.
package fgp_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int ADDR_WIDTH = 5;
  localparam int DATA_WIDTH = 32;
  localparam int VCI_WIDTH  = 16;
  localparam int INCR_WIDTH = 24;
  localparam int LEVEL_WIDTH = 32;
  localparam int COUNT_WIDTH = 16;

  localparam logic [2:0] REG_POLICE_ALL      = 3'd0;
  localparam logic [2:0] REG_POLICE_VCI      = 3'd1;
  localparam logic [2:0] REG_CELL_INCREMENT  = 3'd2;
  localparam logic [2:0] REG_BURST_LIMIT     = 3'd3;
  localparam logic [2:0] REG_MAX_FRAME_CELLS = 3'd4;
  localparam logic [2:0] REG_TAG_MODE        = 3'd5;

  localparam logic                   RST_POLICE_ALL      = 1'b1;
  localparam logic [VCI_WIDTH-1:0]   RST_POLICE_VCI      = 16'd0;
  localparam logic [INCR_WIDTH-1:0]  RST_CELL_INCREMENT  = 24'd256;
  localparam logic [LEVEL_WIDTH-1:0] RST_BURST_LIMIT     = 32'd256;
  localparam logic [COUNT_WIDTH-1:0] RST_MAX_FRAME_CELLS = 16'hFFFF;
  localparam logic                   RST_TAG_MODE        = 1'b0;

  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                   police_all;
    logic [VCI_WIDTH-1:0]   police_vci;
    logic [INCR_WIDTH-1:0]  cell_increment;
    logic [LEVEL_WIDTH-1:0] burst_limit;
    logic [COUNT_WIDTH-1:0] max_frame_cells;
    logic                   tag_mode;
  } cfg_t;

  typedef struct packed {
    logic forwarded;
    logic clp_out;
    logic policed;
    logic frame_too_long;
  } result_t;

endpackage

// ----- hw/rtl/fgp_core.sv -----
// Policing state and combinational F-GCRA decision for one cell.
module fgp_core #(
  parameter int TIME_WIDTH = fgp_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = fgp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fgp_pkg::cfg_t                    cfg,
  input  logic                             take,
  input  logic [fgp_pkg::VCI_WIDTH-1:0]    cell_vci,
  input  logic                             cell_clp,
  input  logic                             end_of_frame,
  input  logic [TIME_WIDTH-1:0]            arrival_time,
  output fgp_pkg::result_t                 result
);
  import fgp_pkg::*;

  localparam int SW = (TIME_WIDTH + FRAC_BITS > LEVEL_WIDTH) ?
                      TIME_WIDTH + FRAC_BITS : LEVEL_WIDTH;

  logic [LEVEL_WIDTH-1:0] bucket_level;
  logic [TIME_WIDTH-1:0]  last_conform_time;
  logic                   expect_first_cell;
  logic                   frame_marked;
  logic [COUNT_WIDTH-1:0] frame_cell_count;

  logic                   hit;
  logic [COUNT_WIDTH-1:0] count_base;
  logic [COUNT_WIDTH-1:0] frame_cell_count_next;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [SW-1:0]          scaled;
  logic [SW-1:0]          level_wide;
  logic [LEVEL_WIDTH-1:0] drained;
  logic                   first_mark;
  logic                   marked;
  logic                   conform;
  logic [LEVEL_WIDTH:0]   sum;
  logic [LEVEL_WIDTH-1:0] bucket_level_next;

  always_comb begin
    hit = cfg.police_all || (cell_vci == cfg.police_vci);
    count_base = expect_first_cell ? '0 : frame_cell_count;
    frame_cell_count_next = (count_base == COUNT_MAX) ? count_base
                                                      : count_base + 1'b1;
    elapsed    = arrival_time - last_conform_time;
    scaled     = SW'(elapsed) << FRAC_BITS;
    level_wide = SW'(bucket_level);
    drained    = (scaled >= level_wide) ? '0 : LEVEL_WIDTH'(level_wide - scaled);
    first_mark = (drained > cfg.burst_limit) || cell_clp;
    marked     = expect_first_cell ? first_mark : frame_marked;
    conform    = !marked;
    sum        = {1'b0, drained} + (LEVEL_WIDTH + 1)'(cfg.cell_increment);
    bucket_level_next = sum[LEVEL_WIDTH] ? LEVEL_MAX : sum[LEVEL_WIDTH-1:0];

    result.policed        = hit;
    result.frame_too_long = hit && (frame_cell_count_next > cfg.max_frame_cells);
    result.forwarded      = !hit || !marked || cfg.tag_mode;
    result.clp_out        = hit ? (marked && cfg.tag_mode) : cell_clp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_level      <= '0;
      last_conform_time <= '0;
      expect_first_cell <= 1'b1;
      frame_marked      <= 1'b0;
      frame_cell_count  <= '0;
    end else if (take && hit) begin
      frame_cell_count  <= frame_cell_count_next;
      expect_first_cell <= end_of_frame;
      frame_marked      <= marked;
      if (conform) begin
        bucket_level      <= bucket_level_next;
        last_conform_time <= arrival_time;
      end
    end
  end

  a_unpoliced_hold: assert property (@(posedge clk) disable iff (rst)
    take && !hit |=> $stable(bucket_level) && $stable(frame_cell_count)
                     && $stable(expect_first_cell))
    else $error("unpoliced cell changed policer state");

  a_marked_frame_hold: assert property (@(posedge clk) disable iff (rst)
    take && hit && !expect_first_cell && frame_marked
      |=> $stable(bucket_level) && $stable(last_conform_time) && frame_marked)
    else $error("marked frame updated the bucket");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    take && hit |=> frame_cell_count != '0)
    else $error("frame cell count zero after policed cell");

endmodule

// ----- hw/rtl/frame_gcra_policer.sv -----
// Top level of the frame GCRA policer: register port, cell handshake, result register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------------
//  cell     | cell_valid / cell_stall     | cell_vci, cell_clp, end_of_frame, arrival_time
//  result   | result_valid / result_stall | forwarded, clp_out, policed, frame_too_long
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata, pready
//
//  One cell per cycle while cell_stall is low; its result is in the result register the cycle after transfer.
//  The bucket drain, burst compare and increment are combinational, so the next cell
//  sees updated state at once.
//  Reset is synchronous; it restores the register defaults and an empty bucket.
//  cell_stall is high only while a held result is stalled.
module frame_gcra_policer #(
  parameter int TIME_WIDTH = fgp_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = fgp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fgp_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [fgp_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [fgp_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                              pready,
  input  logic                              cell_valid,
  output logic                              cell_stall,
  input  logic [fgp_pkg::VCI_WIDTH-1:0]     cell_vci,
  input  logic                              cell_clp,
  input  logic                              end_of_frame,
  input  logic [TIME_WIDTH-1:0]             arrival_time,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              forwarded,
  output logic                              clp_out,
  output logic                              policed,
  output logic                              frame_too_long
);
  import fgp_pkg::*;

  cfg_t       cfg;
  result_t    res_comb;
  result_t    res;
  logic       take;
  logic       wr_en;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.police_all      <= RST_POLICE_ALL;
      cfg.police_vci      <= RST_POLICE_VCI;
      cfg.cell_increment  <= RST_CELL_INCREMENT;
      cfg.burst_limit     <= RST_BURST_LIMIT;
      cfg.max_frame_cells <= RST_MAX_FRAME_CELLS;
      cfg.tag_mode        <= RST_TAG_MODE;
    end else if (wr_en) begin
      case (reg_index)
        REG_POLICE_ALL:      cfg.police_all      <= pwdata[0];
        REG_POLICE_VCI:      cfg.police_vci      <= pwdata[VCI_WIDTH-1:0];
        REG_CELL_INCREMENT:  cfg.cell_increment  <= pwdata[INCR_WIDTH-1:0];
        REG_BURST_LIMIT:     cfg.burst_limit     <= pwdata[LEVEL_WIDTH-1:0];
        REG_MAX_FRAME_CELLS: cfg.max_frame_cells <= pwdata[COUNT_WIDTH-1:0];
        REG_TAG_MODE:        cfg.tag_mode        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_POLICE_ALL:      prdata = DATA_WIDTH'(cfg.police_all);
      REG_POLICE_VCI:      prdata = DATA_WIDTH'(cfg.police_vci);
      REG_CELL_INCREMENT:  prdata = DATA_WIDTH'(cfg.cell_increment);
      REG_BURST_LIMIT:     prdata = DATA_WIDTH'(cfg.burst_limit);
      REG_MAX_FRAME_CELLS: prdata = DATA_WIDTH'(cfg.max_frame_cells);
      REG_TAG_MODE:        prdata = DATA_WIDTH'(cfg.tag_mode);
      default:             prdata = '0;
    endcase
  end

  assign cell_stall = result_valid && result_stall;
  assign take       = cell_valid && !cell_stall;

  fgp_core #(
    .TIME_WIDTH (TIME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .take         (take),
    .cell_vci     (cell_vci),
    .cell_clp     (cell_clp),
    .end_of_frame (end_of_frame),
    .arrival_time (arrival_time),
    .result       (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!cell_stall) begin
      result_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_comb;
    end
  end

  assign forwarded      = res.forwarded;
  assign clp_out        = res.clp_out;
  assign policed        = res.policed;
  assign frame_too_long = res.frame_too_long;

  a_transfer_result: assert property (@(posedge clk) disable iff (rst)
    take |=> result_valid)
    else $error("accepted cell produced no result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(res))
    else $error("stalled result changed");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !cell_valid && !cell_stall |=> !result_valid)
    else $error("result without a cell transfer");

endmodule

// ----- verif/tb_frame_gcra_policer.sv -----
`timescale 1ns / 100ps
// Testbench of frame_gcra_policer: directed and random cell streams checked against a frame GCRA predictor.
module tb_frame_gcra_policer;
  import fgp_pkg::*;

  localparam int QUIET_LIMIT      = 2000;
  localparam int PRINT_LIMIT      = 100;
  localparam int PHASES           = 12;
  localparam int PHASE_CELLS      = 110;
  localparam int LONG_FRAME_CELLS = 110;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_WIDTH-1:0]     paddr;
  logic [DATA_WIDTH-1:0]     pwdata;
  logic [DATA_WIDTH-1:0]     prdata;
  logic                      pready;
  logic                      cell_valid;
  logic                      cell_stall;
  logic [VCI_WIDTH-1:0]      cell_vci;
  logic                      cell_clp;
  logic                      end_of_frame;
  logic [TIME_WIDTH_DEF-1:0] arrival_time;
  logic                      result_valid;
  logic                      result_stall;
  logic                      forwarded;
  logic                      clp_out;
  logic                      policed;
  logic                      frame_too_long;

  cfg_t                      policy;
  logic [LEVEL_WIDTH-1:0]    bkt_level;
  logic [TIME_WIDTH_DEF-1:0] last_conform_tick;
  logic                      at_frame_start;
  logic                      frame_is_marked;
  logic [COUNT_WIDTH-1:0]    cells_in_frame;

  result_t                   expected_verdicts[$];
  int                        error_count;
  bit                        idle_on;
  int                        hold_request;
  logic [31:0]               now_tick;

  frame_gcra_policer i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t police_cell(input logic [VCI_WIDTH-1:0] vci, input logic clp,
                                          input logic eof, input logic [TIME_WIDTH_DEF-1:0] tick);
    result_t                                  verdict;
    logic [TIME_WIDTH_DEF-1:0]                elapsed;
    logic [TIME_WIDTH_DEF+FRAC_BITS_DEF-1:0]  drain_amt;
    logic [LEVEL_WIDTH-1:0]                   level;
    logic [LEVEL_WIDTH:0]                     sum;
    logic                                     oversize;
    if (!policy.police_all && vci != policy.police_vci) begin
      verdict.forwarded      = 1'b1;
      verdict.clp_out        = clp;
      verdict.policed        = 1'b0;
      verdict.frame_too_long = 1'b0;
      return verdict;
    end
    if (at_frame_start) cells_in_frame = '0;
    if (cells_in_frame != COUNT_MAX) cells_in_frame = cells_in_frame + 1'b1;
    oversize  = cells_in_frame > policy.max_frame_cells;
    elapsed   = tick - last_conform_tick;
    drain_amt = {elapsed, {FRAC_BITS_DEF{1'b0}}};
    level     = (drain_amt >= bkt_level) ? '0 : bkt_level - drain_amt[LEVEL_WIDTH-1:0];
    if (at_frame_start) frame_is_marked = (level > policy.burst_limit) || clp;
    if (!frame_is_marked) begin
      sum               = level + policy.cell_increment;
      bkt_level         = sum[LEVEL_WIDTH] ? LEVEL_MAX : sum[LEVEL_WIDTH-1:0];
      last_conform_tick = tick;
    end
    at_frame_start = eof;
    verdict.policed        = 1'b1;
    verdict.frame_too_long = oversize;
    if (frame_is_marked && !policy.tag_mode) begin
      verdict.forwarded = 1'b0;
      verdict.clp_out   = 1'b0;
    end else begin
      verdict.forwarded = 1'b1;
      verdict.clp_out   = frame_is_marked;
    end
    return verdict;
  endfunction

  task automatic flag_field(input string field, input logic want, input logic got);
    if (want !== got) begin
      error_count++;
      if (error_count <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
    end
  endtask

  task automatic send_cell(input logic [VCI_WIDTH-1:0] vci, input logic clp, input logic eof,
                           input logic [TIME_WIDTH_DEF-1:0] tick);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_valid   <= 1'b1;
    cell_vci     <= vci;
    cell_clp     <= clp;
    end_of_frame <= eof;
    arrival_time <= tick;
    do @(posedge clk); while (cell_stall);
    expected_verdicts.push_back(police_cell(vci, clp, eof, tick));
  endtask

  task automatic wait_results_done();
    cell_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_WIDTH-1:0] value);
    logic [DATA_WIDTH-1:0] keep;
    wait_results_done();
    case (idx)
      REG_POLICE_ALL, REG_TAG_MODE:          keep = 32'h1;
      REG_POLICE_VCI, REG_MAX_FRAME_CELLS:   keep = 32'hFFFF;
      REG_CELL_INCREMENT:                    keep = 32'hFF_FFFF;
      default:                               keep = '1;
    endcase
    value   = (value & keep) | ($urandom() & ~keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_POLICE_ALL:      policy.police_all      = value[0];
      REG_POLICE_VCI:      policy.police_vci      = value[VCI_WIDTH-1:0];
      REG_CELL_INCREMENT:  policy.cell_increment  = value[INCR_WIDTH-1:0];
      REG_BURST_LIMIT:     policy.burst_limit     = value[LEVEL_WIDTH-1:0];
      REG_MAX_FRAME_CELLS: policy.max_frame_cells = value[COUNT_WIDTH-1:0];
      REG_TAG_MODE:        policy.tag_mode        = value[0];
      default: ;
    endcase
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_cell(16'h0000, 1'b0, 1'b0, 32'h0000_0000);
    send_cell(16'hFFFF, 1'b1, 1'b1, 32'h0000_0000);
    send_cell(16'h0000, 1'b0, 1'b1, 32'h0000_0000);
    send_cell(16'h1234, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_cell(16'h1234, 1'b0, 1'b1, 32'h0000_0001);
    send_cell(16'h0000, 1'b1, 1'b0, 32'h0000_0002);
    send_cell(16'h0000, 1'b0, 1'b1, 32'h0000_0002);
    write_reg(REG_TAG_MODE, 32'd1);
    write_reg(REG_MAX_FRAME_CELLS, 32'd0);
    write_reg(REG_CELL_INCREMENT, 32'd0);
    write_reg(REG_BURST_LIMIT, 32'd0);
    send_cell(16'h0005, 1'b0, 1'b1, 32'd10);
    send_cell(16'h0005, 1'b0, 1'b0, 32'd10);
    write_reg(REG_CELL_INCREMENT, 32'd300);
    send_cell(16'h0005, 1'b0, 1'b1, 32'd10);
    send_cell(16'h0005, 1'b0, 1'b1, 32'd10);
    send_cell(16'h0005, 1'b0, 1'b1, 32'd12);
    write_reg(REG_POLICE_ALL, 32'd0);
    write_reg(REG_POLICE_VCI, 32'h0000_ABCD);
    write_reg(REG_MAX_FRAME_CELLS, 32'd2);
    send_cell(16'hABCC, 1'b1, 1'b0, 32'd20);
    send_cell(16'hABCD, 1'b0, 1'b0, 32'd20);
    send_cell(16'h0000, 1'b0, 1'b0, 32'd20);
    send_cell(16'hABCD, 1'b1, 1'b0, 32'd20);
    send_cell(16'hABCD, 1'b0, 1'b1, 32'd20);
    write_reg(REG_POLICE_ALL, 32'd1);
    write_reg(REG_BURST_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_CELL_INCREMENT, 32'hFF_FFFF);
    write_reg(REG_MAX_FRAME_CELLS, 32'hFFFF);
    write_reg(REG_TAG_MODE, 32'd0);
    send_cell(16'h8001, 1'b0, 1'b0, 32'h8000_0000);
    send_cell(16'h8001, 1'b1, 1'b0, 32'h8000_0000);
    send_cell(16'h8001, 1'b0, 1'b1, 32'h8000_0000);
    send_cell(16'h7FFE, 1'b0, 1'b1, 32'h8000_0001);
    wait_results_done();
  endtask

  task automatic test_long_frame();
    idle_on = 1'b0;
    write_reg(REG_POLICE_ALL, 32'd1);
    write_reg(REG_CELL_INCREMENT, 32'hFF_FFFF);
    write_reg(REG_BURST_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_MAX_FRAME_CELLS, 32'd100);
    write_reg(REG_TAG_MODE, 32'd0);
    for (int k = 0; k < LONG_FRAME_CELLS; k++)
      send_cell(16'h0042, (k == 0) ? 1'b0 : 1'($urandom_range(0, 1)),
                k == LONG_FRAME_CELLS - 1, 32'h7000_0000);
    wait_results_done();
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_request = 60;
    for (int k = 0; k < 24; k++) begin
      now_tick = now_tick + 1;
      send_cell(16'($urandom()), 1'b0, k % 4 == 3, now_tick);
    end
    wait_results_done();
    for (int k = 0; k < 8; k++) begin
      now_tick = now_tick + 2;
      send_cell(16'($urandom()), 1'($urandom_range(0, 1)), 1'b1, now_tick);
    end
    wait_results_done();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [DATA_WIDTH-1:0] incr;
    logic [DATA_WIDTH-1:0] burst;
    logic [DATA_WIDTH-1:0] max_cells;
    logic [VCI_WIDTH-1:0]  vci;
    int                    sent;
    int                    len;
    int                    span;
    for (int phase = 0; phase < PHASES; phase++) begin
      case ((phase < 2) ? phase : $urandom_range(2, 6))
        0:       incr = 32'hFF_FFFF;
        1:       incr = 32'd0;
        2:       incr = 32'hFF_FFFF;
        3:       incr = 32'd0;
        default: incr = $urandom_range(1, 4096);
      endcase
      case ((phase < 2) ? phase : $urandom_range(0, 3))
        0:       burst = 32'd0;
        1:       burst = 32'hFFFF_FFFF;
        default: burst = $urandom_range(0, incr * 4 + 256);
      endcase
      case ($urandom_range(0, 4))
        0:       max_cells = 32'd0;
        1:       max_cells = 32'hFFFF;
        2:       max_cells = 32'd1;
        default: max_cells = $urandom_range(2, 10);
      endcase
      write_reg(REG_POLICE_ALL, $urandom_range(0, 1));
      write_reg(REG_POLICE_VCI, $urandom());
      write_reg(REG_CELL_INCREMENT, incr);
      write_reg(REG_BURST_LIMIT, burst);
      write_reg(REG_MAX_FRAME_CELLS, max_cells);
      write_reg(REG_TAG_MODE, $urandom_range(0, 1));
      idle_on = (phase % 3 != 2);
      span    = policy.cell_increment >> FRAC_BITS_DEF;
      sent    = 0;
      while (sent < PHASE_CELLS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_cell($urandom_range(0, 1) ? 16'($urandom()) : policy.police_vci,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
          sent++;
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
          vci = policy.police_all ? 16'($urandom()) : policy.police_vci;
          for (int k = 0; k < len; k++) begin
            now_tick = now_tick + $urandom_range(0, (k == 0) ? 2 * span + 2 : span / 2 + 1);
            send_cell(vci, (k == 0) ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1)),
                      k == len - 1, now_tick);
          end
          sent += len;
        end
      end
    end
    wait_results_done();
  endtask

  initial begin : result_sink
    int      wait_left;
    result_t want;
    wait_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (expected_verdicts.size() == 0) begin
          error_count++;
          if (error_count <= PRINT_LIMIT)
            $display("%0t: result transfer with none expected, actual %b%b%b%b", $time,
                     forwarded, clp_out, policed, frame_too_long);
        end else begin
          want = expected_verdicts.pop_front();
          flag_field("forwarded", want.forwarded, forwarded);
          flag_field("clp_out", want.clp_out, clp_out);
          flag_field("policed", want.policed, policed);
          flag_field("frame_too_long", want.frame_too_long, frame_too_long);
        end
        wait_left = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (hold_request > 0) begin
        wait_left    = hold_request;
        hold_request = 0;
      end
      result_stall <= (wait_left > 0);
      if (wait_left > 0) wait_left--;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cell_valid && !cell_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_frame_gcra_policer: errors");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cell_valid   <= 1'b0;
    cell_vci     <= '0;
    cell_clp     <= 1'b0;
    end_of_frame <= 1'b0;
    arrival_time <= '0;
    policy.police_all      = RST_POLICE_ALL;
    policy.police_vci      = RST_POLICE_VCI;
    policy.cell_increment  = RST_CELL_INCREMENT;
    policy.burst_limit     = RST_BURST_LIMIT;
    policy.max_frame_cells = RST_MAX_FRAME_CELLS;
    policy.tag_mode        = RST_TAG_MODE;
    bkt_level         = '0;
    last_conform_tick = '0;
    at_frame_start    = 1'b1;
    frame_is_marked   = 1'b0;
    cells_in_frame    = '0;
    error_count       = 0;
    idle_on           = 1'b1;
    hold_request      = 0;
    now_tick          = 32'hFFFF_FF00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_frame();
    test_backpressure();
    test_random_traffic();
    wait_results_done();
    repeat (4) @(posedge clk);
    if (error_count == 0) $display("tb_frame_gcra_policer: clean");
    else $display("tb_frame_gcra_policer: errors");
    $finish;
  end

endmodule
